>>> sv/jdt_pkg.sv
// Package: sizes, operation and status codes, state encoding for the job dispatch table.
package jdt_pkg;

   localparam int JobSlots    = 16;
   localparam int BatchSlots  = 8;
   localparam int ThreadBits  = 8;
   localparam int JobIdxBits  = $clog2(JobSlots);
   localparam int BatIdxBits  = $clog2(BatchSlots);
   localparam int JobCntBits  = $clog2(JobSlots + 1);
   localparam int BatCntBits  = $clog2(BatchSlots + 1);
   localparam int AffBits     = ThreadBits + 1;
   localparam logic [AffBits-1:0] AffNone = '1;

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_NEXT    = 3'd1,
      OP_CLEAR   = 3'd2,
      OP_BLOCK   = 3'd3,
      OP_UNBLOCK = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NONE      = 2'd1,
      ST_JOB_FULL  = 2'd2,
      ST_BAT_FULL  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_JSCAN = 5'b00010,
      S_BSCAN = 5'b00100,
      S_APPLY = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  worker_id;
      logic        keep_on_thread;
      logic [63:0] job_function;
      logic [63:0] job_argument;
      logic        last_of_batch;
      logic [31:0] target_id;
      logic [2:0]  counter_slot;
   } req_type;

   typedef struct packed {
      logic [31:0] returned_id;
      logic [63:0] out_function;
      logic [63:0] out_argument;
      logic        thread_locked;
      logic [2:0]  slot_handle;
      logic [1:0]  status;
      logic [3:0]  batches_in_use;
      logic [4:0]  jobs_in_use;
      logic        has_work;
   } rsp_type;

endpackage

>>> sv/jdt_if.sv
// Interfaces: request and response valid/ready channels.
interface jdt_req_if;
   logic             valid;
   logic             ready;
   jdt_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface jdt_rsp_if;
   logic             valid;
   logic             ready;
   jdt_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/job_dispatch_table.sv
// Top level: job table with batch tracking, one slot examined per cycle.
// Each request is handled by a sequencer that walks the job slots one per
// cycle and then the batch slots one per cycle, with a single compare/age
// unit, followed by an update state and a count state that raises the
// response beat; the next request is taken only once rsp.ready has taken
// that response, so rsp.ready held low stalls the table. req.ready is high
// only while idle; the response register holds until rsp.ready takes it.
module job_dispatch_table (
   input  logic          clock,
   input  logic          reset,
   jdt_req_if.sink       req,
   jdt_rsp_if.source     rsp
);

   localparam int JB = jdt_pkg::JobIdxBits;
   localparam int BB = jdt_pkg::BatIdxBits;

   logic [31:0]               job_id_mem  [jdt_pkg::JobSlots];
   logic [63:0]               fn_mem      [jdt_pkg::JobSlots];
   logic [63:0]               arg_mem     [jdt_pkg::JobSlots];
   logic [jdt_pkg::AffBits-1:0] aff_mem   [jdt_pkg::JobSlots];
   logic [31:0]               owner_mem   [jdt_pkg::JobSlots];
   logic [jdt_pkg::JobSlots-1:0] busy_ff, valid_ff;
   logic [31:0]               bid_mem     [jdt_pkg::BatchSlots];
   logic [4:0]                brem_ff     [jdt_pkg::BatchSlots];
   logic [jdt_pkg::BatchSlots-1:0] bblk_ff, blive_ff;
   logic [31:0]               next_job_ff, next_bat_ff;
   logic                      open_ff;
   logic [BB-1:0]             open_idx_ff;
   logic [jdt_pkg::JobCntBits-1:0] njobs_ff;
   logic [jdt_pkg::BatCntBits-1:0] nbats_ff;

   jdt_pkg::state_type        state_ff;
   jdt_pkg::req_type          r_ff;
   logic [JB:0]               jcnt_ff;
   logic [BB:0]               bcnt_ff;
   logic                      jfound_ff, bfound_ff;
   logic [JB-1:0]             jsel_ff;
   logic [BB-1:0]             bsel_ff;
   logic [31:0]               best_age_ff;
   jdt_pkg::rsp_type          rsp_ff;
   logic                      rsp_valid_ff;

   logic [JB-1:0]             ji;
   logic [BB-1:0]             bi;
   logic [31:0]               bkey;
   logic                      jhit, bhit;
   logic [31:0]               age;
   logic [jdt_pkg::ThreadBits-1:0] thr;

   assign ji  = jcnt_ff[JB-1:0];
   assign bi  = bcnt_ff[BB-1:0];
   assign thr = r_ff.worker_id[jdt_pkg::ThreadBits-1:0];
   assign age = next_job_ff - job_id_mem[ji];
   assign bkey = (r_ff.operation == jdt_pkg::OP_CLEAR) ? owner_mem[jsel_ff] : r_ff.target_id;

   always_comb begin
      jhit = 1'b0;
      case (r_ff.operation)
         jdt_pkg::OP_ADD:   jhit = !valid_ff[ji];
         jdt_pkg::OP_NEXT:  jhit = valid_ff[ji] && !busy_ff[ji] &&
                                  (aff_mem[ji] == jdt_pkg::AffNone ||
                                   aff_mem[ji] == {1'b0, thr}) &&
                                  (!jfound_ff || age > best_age_ff);
         jdt_pkg::OP_CLEAR: jhit = valid_ff[ji] && job_id_mem[ji] == r_ff.target_id;
         default:           jhit = 1'b0;
      endcase
      if (r_ff.operation == jdt_pkg::OP_ADD)
         bhit = !blive_ff[bi];
      else
         bhit = blive_ff[bi] && bid_mem[bi] == bkey;
   end

   assign req.ready = (state_ff == jdt_pkg::S_IDLE) && !reset;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // apply stage helpers
   logic [BB-1:0]    ob;
   logic [BB-1:0]    ub;
   logic [4:0]       rem_dec;
   logic             add_ok, unb_ok, clr_retire, unb_retire;
   jdt_pkg::rsp_type rsp_in;

   assign ub = r_ff.counter_slot[BB-1:0];
   assign ob = open_ff ? open_idx_ff : bsel_ff;
   assign rem_dec = brem_ff[bsel_ff] - 5'd1;
   assign add_ok = jfound_ff && (open_ff || bfound_ff);
   assign unb_ok = (32'(r_ff.counter_slot) < 32'(jdt_pkg::BatchSlots)) && blive_ff[ub];
   assign clr_retire = bfound_ff && rem_dec == 5'd0 && !bblk_ff[bsel_ff] &&
                       !(open_ff && open_idx_ff == bsel_ff);
   assign unb_retire = brem_ff[ub] == 5'd0 && !(open_ff && open_idx_ff == ub);

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = jdt_pkg::ST_NONE;
      case (r_ff.operation)
         jdt_pkg::OP_ADD: begin
            if (!jfound_ff)
               rsp_in.status = jdt_pkg::ST_JOB_FULL;
            else if (!add_ok)
               rsp_in.status = jdt_pkg::ST_BAT_FULL;
            else begin
               rsp_in.returned_id = open_ff ? bid_mem[ob] : next_bat_ff + 32'd1;
               rsp_in.status      = jdt_pkg::ST_OK;
            end
         end
         jdt_pkg::OP_NEXT: begin
            if (jfound_ff) begin
               rsp_in.returned_id   = job_id_mem[jsel_ff];
               rsp_in.out_function  = fn_mem[jsel_ff];
               rsp_in.out_argument  = arg_mem[jsel_ff];
               rsp_in.thread_locked = aff_mem[jsel_ff] != jdt_pkg::AffNone;
               rsp_in.status        = jdt_pkg::ST_OK;
            end
         end
         jdt_pkg::OP_CLEAR: begin
            if (jfound_ff) begin
               rsp_in.status = jdt_pkg::ST_OK;
               if (clr_retire)
                  rsp_in.returned_id = bid_mem[bsel_ff];
            end
         end
         jdt_pkg::OP_BLOCK: begin
            if (bfound_ff) begin
               rsp_in.slot_handle = 3'(bsel_ff);
               rsp_in.status      = jdt_pkg::ST_OK;
            end
         end
         jdt_pkg::OP_UNBLOCK: begin
            if (unb_ok) begin
               rsp_in.status = jdt_pkg::ST_OK;
               if (unb_retire)
                  rsp_in.returned_id = bid_mem[ub];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jdt_pkg::S_IDLE;
         busy_ff      <= '0;
         valid_ff     <= '0;
         bblk_ff      <= '0;
         blive_ff     <= '0;
         next_job_ff  <= '0;
         next_bat_ff  <= '0;
         open_ff      <= 1'b0;
         open_idx_ff  <= '0;
         njobs_ff     <= '0;
         nbats_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < jdt_pkg::BatchSlots; k++) brem_ff[k] <= '0;
      end else begin
         case (state_ff)
            jdt_pkg::S_IDLE: begin
               if (req.valid) begin
                  r_ff        <= req.payload;
                  jcnt_ff     <= '0;
                  bcnt_ff     <= '0;
                  jfound_ff   <= 1'b0;
                  bfound_ff   <= 1'b0;
                  best_age_ff <= '0;
                  state_ff    <= jdt_pkg::S_JSCAN;
               end
            end
            jdt_pkg::S_JSCAN: begin
               if (jhit && !(jfound_ff && r_ff.operation != jdt_pkg::OP_NEXT)) begin
                  jfound_ff   <= 1'b1;
                  jsel_ff     <= ji;
                  best_age_ff <= age;
               end
               if (jcnt_ff == (JB+1)'(jdt_pkg::JobSlots - 1))
                  state_ff <= jdt_pkg::S_BSCAN;
               jcnt_ff <= jcnt_ff + 1'b1;
            end
            jdt_pkg::S_BSCAN: begin
               if (bhit && !bfound_ff) begin
                  bfound_ff <= 1'b1;
                  bsel_ff   <= bi;
               end
               if (bcnt_ff == (BB+1)'(jdt_pkg::BatchSlots - 1))
                  state_ff <= jdt_pkg::S_APPLY;
               bcnt_ff <= bcnt_ff + 1'b1;
            end
            jdt_pkg::S_APPLY: begin
               rsp_ff   <= rsp_in;
               state_ff <= jdt_pkg::S_DONE;
               case (r_ff.operation)
                  jdt_pkg::OP_ADD: begin
                     if (add_ok) begin
                        if (!open_ff) begin
                           bid_mem[bsel_ff] <= next_bat_ff + 32'd1;
                           bblk_ff[bsel_ff] <= 1'b0;
                           blive_ff[bsel_ff] <= 1'b1;
                           next_bat_ff <= next_bat_ff + 32'd1;
                           nbats_ff <= nbats_ff + 1'b1;
                           open_idx_ff <= bsel_ff;
                           brem_ff[bsel_ff] <= 5'd1;
                           owner_mem[jsel_ff] <= next_bat_ff + 32'd1;
                        end else begin
                           brem_ff[ob] <= brem_ff[ob] + 5'd1;
                           owner_mem[jsel_ff] <= bid_mem[ob];
                        end
                        open_ff <= !r_ff.last_of_batch;
                        next_job_ff <= next_job_ff + 32'd1;
                        job_id_mem[jsel_ff] <= next_job_ff + 32'd1;
                        fn_mem[jsel_ff]  <= r_ff.job_function;
                        arg_mem[jsel_ff] <= r_ff.job_argument;
                        aff_mem[jsel_ff] <= r_ff.keep_on_thread ? {1'b0, thr}
                                                                : jdt_pkg::AffNone;
                        busy_ff[jsel_ff]  <= 1'b0;
                        valid_ff[jsel_ff] <= 1'b1;
                        njobs_ff <= njobs_ff + 1'b1;
                     end
                  end
                  jdt_pkg::OP_NEXT: begin
                     if (jfound_ff)
                        busy_ff[jsel_ff] <= 1'b1;
                  end
                  jdt_pkg::OP_CLEAR: begin
                     if (jfound_ff) begin
                        valid_ff[jsel_ff] <= 1'b0;
                        busy_ff[jsel_ff]  <= 1'b0;
                        njobs_ff <= njobs_ff - 1'b1;
                        if (bfound_ff)
                           brem_ff[bsel_ff] <= rem_dec;
                        if (clr_retire) begin
                           blive_ff[bsel_ff] <= 1'b0;
                           nbats_ff <= nbats_ff - 1'b1;
                        end
                     end
                  end
                  jdt_pkg::OP_BLOCK: begin
                     if (bfound_ff)
                        bblk_ff[bsel_ff] <= 1'b1;
                  end
                  jdt_pkg::OP_UNBLOCK: begin
                     if (unb_ok) begin
                        bblk_ff[ub] <= 1'b0;
                        if (unb_retire) begin
                           blive_ff[ub] <= 1'b0;
                           nbats_ff <= nbats_ff - 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            jdt_pkg::S_DONE: begin
               if (!rsp_valid_ff) begin
                  rsp_ff.batches_in_use <= 4'(nbats_ff);
                  rsp_ff.jobs_in_use    <= 5'(njobs_ff);
                  rsp_ff.has_work       <= (nbats_ff != '0) || (njobs_ff != '0);
                  rsp_valid_ff <= 1'b1;
               end else if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= jdt_pkg::S_IDLE;
               end
            end
            default: state_ff <= jdt_pkg::S_IDLE;
         endcase
      end
   end

endmodule
